[design/rlespr_pkg.sv]
// Shared types, constants and the pixel remap function for the run-length sprite pixel format converter.
// No dependencies.
package rlespr_pkg;

    // Parse phase within a sprite line
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_COUNT  = 2'd2,
        PH_PIXEL  = 2'd3
    } t_phase;

    // Pixel remap modes; the two codes above the pass code also pass
    typedef enum logic [2:0] {
        MODE_555_OPAQUE = 3'd0,
        MODE_555_PLAIN  = 3'd1,
        MODE_GREEN_LSB  = 3'd2,
        MODE_SHADOW     = 3'd3,
        MODE_555_TO_565 = 3'd4,
        MODE_PASS       = 3'd5
    } t_mode;

    // Configuration register indexes
    localparam logic [1:0] REG_CONVERT_MODE = 2'd0;
    localparam logic [1:0] REG_LINE_COUNT   = 2'd1;

    localparam int WORD_W = 16;
    localparam int CFG_INDEX_W = 2;

    typedef logic [WORD_W-1:0] t_word;

    // Bit masks of the remaps
    localparam t_word MASK_565_RB_HI = 16'hffc0;
    localparam t_word MASK_BLUE      = 16'h001f;
    localparam t_word BIT_OPAQUE     = 16'h8000;
    localparam t_word MASK_555_RG    = 16'h7fe0;
    localparam t_word BIT_GREEN_LSB  = 16'h0020;

    // Remap one pixel word by mode
    function automatic t_word remap_pixel(input t_mode mode, input t_word w);
        t_word r;
        case (mode)
            MODE_555_OPAQUE: r = ((w & MASK_565_RB_HI) >> 1) | (w & MASK_BLUE) | BIT_OPAQUE;
            MODE_555_PLAIN:  r = ((w & MASK_565_RB_HI) >> 1) | (w & MASK_BLUE);
            MODE_GREEN_LSB:  r = w | BIT_GREEN_LSB;
            MODE_SHADOW:     r = '0;
            MODE_555_TO_565: r = ((w & MASK_555_RG) << 1) | (w & MASK_BLUE);
            default:         r = w;
        endcase
        return r;
    endfunction

endpackage

[design/rle_sprite_pixel_format_converter.sv]
// Top level of the run-length sprite pixel format converter: parser, remap
// and result register. Depends on rlespr_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one 16-bit sprite word
//   and a first-word flag per item. The first word of a sprite must carry
//   i_first_word = 1; it starts a new parse with line_count lines.
//   Output channel (o_out_valid / i_out_stall) carries one result item per
//   input item: the word (remapped if it is a pixel), a pixel flag, an
//   end-of-sprite flag on the word that completes the last line, and an
//   overrun flag for words arriving when no sprite is in progress.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes convert_mode
//   (index 0) and line_count (index 1); other indexes are ignored. Write it
//   only while the block is idle. o_cfg_ready is always high.
//   The result of an item is valid in the cycle after it is accepted.
//   Throughput is one item per cycle, set by the single result register:
//   the block takes a new item whenever that register is empty or is
//   being emptied in the same cycle.
//   When the receiver stalls with a result pending, o_in_stall rises and the
//   pending result holds unchanged.
//   Reset clears both registers, empties the result register and leaves the
//   parser idle, so words before the first sprite come out as overruns.
module rle_sprite_pixel_format_converter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [rlespr_pkg::WORD_W-1:0]         i_in_word,
    input  logic                                  i_first_word,
    // Output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [rlespr_pkg::WORD_W-1:0]         o_out_word,
    output logic                                  o_is_pixel,
    output logic                                  o_sprite_end,
    output logic                                  o_overrun,
    // Configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rlespr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [rlespr_pkg::WORD_W-1:0]         i_cfg_data
);
    import rlespr_pkg::*;

    // Configuration registers
    t_mode  r_mode;
    t_word  r_line_count;

    // Parser state
    t_phase r_phase, n_phase;
    t_word  r_lines_left, n_lines_left;
    t_word  r_nodes_left, n_nodes_left;
    t_word  r_pixels_left, n_pixels_left;
    logic   r_done, n_done;

    // Result register
    logic   r_out_valid;
    t_word  r_out_word, n_out_word;
    logic   r_is_pixel, n_is_pixel;
    logic   r_sprite_end, n_sprite_end;
    logic   r_overrun, n_overrun;

    // Parser state after a possible restart
    t_phase s_phase;
    t_word  s_lines_left;
    t_word  s_nodes_left;
    t_word  s_pixels_left;
    logic   s_done;

    logic   in_accept;
    logic   node_finish;
    logic   line_finish;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_555_OPAQUE;
            r_line_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CONVERT_MODE: r_mode <= t_mode'(i_cfg_data[2:0]);
                REG_LINE_COUNT:   r_line_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Apply a restart before parsing the word
    always_comb begin
        if (i_first_word) begin
            s_phase       = PH_HEADER;
            s_lines_left  = r_line_count;
            s_nodes_left  = '0;
            s_pixels_left = '0;
            s_done        = (r_line_count == '0);
        end else begin
            s_phase       = r_phase;
            s_lines_left  = r_lines_left;
            s_nodes_left  = r_nodes_left;
            s_pixels_left = r_pixels_left;
            s_done        = r_done;
        end
    end

    // Parse the word and remap pixels
    always_comb begin
        n_phase       = s_phase;
        n_lines_left  = s_lines_left;
        n_nodes_left  = s_nodes_left;
        n_pixels_left = s_pixels_left;
        n_done        = s_done;
        n_out_word    = i_in_word;
        n_is_pixel    = 1'b0;
        n_overrun     = 1'b0;
        node_finish   = 1'b0;
        line_finish   = 1'b0;

        if (s_done) begin
            n_overrun = 1'b1;
        end else begin
            case (s_phase)
                PH_HEADER: begin
                    if (i_in_word == '0) begin
                        line_finish = 1'b1;
                    end else begin
                        n_nodes_left = i_in_word;
                        n_phase      = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (i_in_word == '0) begin
                        node_finish = 1'b1;
                    end else begin
                        n_pixels_left = i_in_word;
                        n_phase       = PH_PIXEL;
                    end
                end
                default: begin
                    n_out_word    = remap_pixel(r_mode, i_in_word);
                    n_is_pixel    = 1'b1;
                    n_pixels_left = s_pixels_left - 1'b1;
                    node_finish   = (s_pixels_left == t_word'(1));
                end
            endcase

            // Close a node; its last one closes the line
            if (node_finish) begin
                n_nodes_left = s_nodes_left - 1'b1;
                if (s_nodes_left == t_word'(1)) begin
                    line_finish = 1'b1;
                end else begin
                    n_phase = PH_SKIP;
                end
            end

            // Close a line; its last one ends the sprite
            if (line_finish) begin
                n_phase      = PH_HEADER;
                n_lines_left = s_lines_left - 1'b1;
                if (s_lines_left == t_word'(1)) begin
                    n_done = 1'b1;
                end
            end
        end

        n_sprite_end = line_finish && (s_lines_left == t_word'(1));
    end

    // Advance parser state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_lines_left  <= '0;
            r_nodes_left  <= '0;
            r_pixels_left <= '0;
            r_done        <= 1'b1;
        end else if (in_accept) begin
            r_phase       <= n_phase;
            r_lines_left  <= n_lines_left;
            r_nodes_left  <= n_nodes_left;
            r_pixels_left <= n_pixels_left;
            r_done        <= n_done;
        end
    end

    // Hold or load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word   <= n_out_word;
            r_is_pixel   <= n_is_pixel;
            r_sprite_end <= n_sprite_end;
            r_overrun    <= n_overrun;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_word   = r_out_word;
    assign o_is_pixel   = r_is_pixel;
    assign o_sprite_end = r_sprite_end;
    assign o_overrun    = r_overrun;

endmodule
